[rtl/core/pida_pkg.sv]
// Package for the positional insert/delete array.
// Holds sizes, opcode and status codes, and the controller/datapath interface types.
// No dependencies.
package pida_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int IDX_BITS  = $clog2(DEPTH);
  // Width used to compare positions and counts against each other.
  localparam int CMP_BITS  = 7;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_FRONT  = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_DUMP   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic step;    // emit one dump word and rotate the array
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic slot_free;   // output register can be loaded this cycle
    logic count_zero;  // array is empty
    logic dump_last;   // current dump word is the final one
  } stat_t;

endpackage

[rtl/core/pida_ctrl.sv]
// Controller for the positional insert/delete array.
// Sequences input transfers and dump streaming; depends on pida_pkg.
module pida_ctrl
  import pida_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_opcode,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = stat.slot_free;
        cmd.accept = in_valid && stat.slot_free;
        // A dump of a non-empty array streams one word per free output slot.
        if (cmd.accept && (in_opcode == OP_DUMP) && !stat.count_zero) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        cmd.step = stat.slot_free;
        if (cmd.step && stat.dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/pida_dpath.sv]
// Datapath for the positional insert/delete array: shifting word cells,
// fill count, dump index and the output register. Depends on pida_pkg.
module pida_dpath
  import pida_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [6:0]         out_fill_count,
  output logic signed [31:0] out_value_out,
  output logic [5:0]         out_entry_index,
  output logic               out_last
);

  word_t                cells_r   [DEPTH];
  word_t                cells_nxt [DEPTH];
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic [IDX_BITS-1:0]  dump_idx_r, dump_idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [6:0]           out_fill_r, out_fill_nxt;
  logic signed [31:0]   out_value_r, out_value_nxt;
  logic [5:0]           out_index_r, out_index_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [CMP_BITS-1:0]  cnt_c;
  logic [CMP_BITS-1:0]  pos_c;
  logic [CMP_BITS-1:0]  ins_pos;
  logic                 full;
  logic                 do_ins;
  logic                 do_del;
  logic                 ins_ok;
  logic                 del_ok;
  word_t                new_word;

  assign cnt_c    = CMP_BITS'(count_r);
  assign pos_c    = CMP_BITS'(in_position);
  assign full     = (cnt_c == CMP_BITS'(DEPTH));
  assign new_word = WORD_BITS'(in_value_in);

  always_comb begin
    unique case (in_opcode)
      OP_FRONT:  ins_pos = '0;
      OP_INSERT: ins_pos = pos_c;
      default:   ins_pos = cnt_c;
    endcase
  end

  assign ins_ok = !full && ((in_opcode != OP_INSERT) || (pos_c <= cnt_c));
  assign del_ok = (pos_c < cnt_c);
  assign do_ins = cmd.accept && ins_ok &&
                  ((in_opcode == OP_APPEND) || (in_opcode == OP_FRONT) ||
                   (in_opcode == OP_INSERT));
  assign do_del = cmd.accept && del_ok && (in_opcode == OP_DELETE);

  // Each cell picks from its own value, its neighbors, the new word, or cell 0
  // (during a dump the occupied cells rotate so cell 0 is always the word to send).
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CMP_BITS-1:0] G = CMP_BITS'(g);
    word_t below;
    word_t above;
    if (g > 0) begin : g_below
      assign below = cells_r[g-1];
    end else begin : g_below0
      assign below = cells_r[0];
    end
    if (g < DEPTH - 1) begin : g_above
      assign above = cells_r[g+1];
    end else begin : g_abovel
      assign above = cells_r[g];
    end
    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (do_ins) begin
        if (G == ins_pos) begin
          cells_nxt[g] = new_word;
        end else if ((G > ins_pos) && (G <= cnt_c)) begin
          cells_nxt[g] = below;
        end
      end else if (do_del) begin
        if ((G >= pos_c) && (G + 1'b1 < cnt_c)) begin
          cells_nxt[g] = above;
        end
      end else if (cmd.step) begin
        if (G + 1'b1 < cnt_c) begin
          cells_nxt[g] = above;
        end else if (G + 1'b1 == cnt_c) begin
          cells_nxt[g] = cells_r[0];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_del) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    dump_idx_nxt = dump_idx_r;
    if (cmd.accept) begin
      dump_idx_nxt = '0;
    end else if (cmd.step) begin
      dump_idx_nxt = dump_idx_r + 1'b1;
    end
  end

  assign stat.slot_free  = !out_valid_r || out_ready;
  assign stat.count_zero = (count_r == '0);
  assign stat.dump_last  = (CMP_BITS'(dump_idx_r) + 1'b1 == cnt_c);

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    if (cmd.step) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_fill_nxt   = 7'(count_r);
      out_value_nxt  = 32'(cells_r[0]);
      out_index_nxt  = 6'(dump_idx_r);
      out_last_nxt   = stat.dump_last;
    end else if (cmd.accept) begin
      out_fill_nxt  = 7'(count_nxt);
      out_value_nxt = '0;
      out_index_nxt = '0;
      out_last_nxt  = 1'b1;
      unique case (in_opcode)
        OP_APPEND, OP_FRONT, OP_INSERT: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = full ? ST_FULL : (ins_ok ? ST_OK : ST_RANGE);
        end
        OP_DELETE: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = del_ok ? ST_OK : ST_RANGE;
        end
        OP_DUMP: begin
          // A non-empty dump sends its words through the step path.
          if (stat.count_zero) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r      <= cells_nxt;
    dump_idx_r   <= dump_idx_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_fill_count  = out_fill_r;
  assign out_value_out   = out_value_r;
  assign out_entry_index = out_index_r;
  assign out_last        = out_last_r;

endmodule

[rtl/core/positional_insert_delete_array_top.sv]
// Top level of the positional insert/delete array.
// Joins pida_ctrl and pida_dpath; depends on pida_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    opcode, position, value_in
//   out_     output     out_valid/out_ready  status, fill_count, value_out,
//                                            entry_index, last
//
// The result of a mutation or an empty dump is registered at the transfer edge and
// offered in the next cycle; an unused opcode gives no result.
// A dump of N words is taken at the transfer edge, then sends one word per edge
// while the output is taken. The occupied cells rotate by one per word, so the
// array is intact afterward, and input is held off until the final word leaves.
// Outside a dump, input is taken whenever the output register is empty or being drained.
// Synchronous active-low reset clears the fill count and the output valid flag.
module positional_insert_delete_array_top
  import pida_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [6:0]         out_fill_count,
  output logic signed [31:0] out_value_out,
  output logic [5:0]         out_entry_index,
  output logic               out_last
);

  cmd_t  cmd;
  stat_t stat;

  pida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pida_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_fill_count  (out_fill_count),
    .out_value_out   (out_value_out),
    .out_entry_index (out_entry_index),
    .out_last        (out_last)
  );

endmodule
